// ----- hdl/line_sensor_centroid_tracker_macros.svh -----
// assertion macros shared by the line sensor centroid tracker rtl
`ifndef LINE_SENSOR_CENTROID_TRACKER_MACROS_SVH
`define LINE_SENSOR_CENTROID_TRACKER_MACROS_SVH

// property must hold at every clock edge out of reset
`define LSCT_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen out of reset
`define LSCT_NEVER(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- hdl/lsct_pkg.sv -----
// types, constants and helpers shared by the line sensor centroid tracker
package lsct_pkg;

    localparam int MAX_CH     = 7;
    localparam int W_W        = 13;
    localparam int SUM_W      = 16;
    localparam int DIV_STEPS  = SUM_W - 1;
    localparam int CNT_W      = 3;
    localparam int KIND_W     = 2;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    localparam logic [KIND_W-1:0] KIND_TRACK = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WHITE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BLACK = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd3;

    localparam logic [REG_IDX_W-1:0] REG_GLOBAL_INVERT = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_WEIGHT0       = 3'd1;

    typedef logic signed [W_W-1:0] weight_t;
    typedef logic [MAX_CH-1:0][W_W-1:0] weight_arr_t;

    localparam weight_arr_t WEIGHT_RST = {
        13'sd3000, 13'sd2000, 13'sd1000, 13'sd0,
        -13'sd1000, -13'sd2000, -13'sd3000
    };

    typedef struct packed {
        logic              start;
        logic [MAX_CH-1:0] line;
    } cen_req_t;

    typedef struct packed {
        logic             done;
        logic             found;
        logic [CNT_W-1:0] count;
        weight_t          err;
    } cen_rsp_t;

    typedef struct packed {
        logic              capture;
        logic              clear;
        logic              black;
        logic [MAX_CH-1:0] bits;
    } calib_req_t;

    typedef struct packed {
        logic [MAX_CH-1:0] mask;
        logic              calibrated;
        logic              done_now;
        logic              cal_after;
    } calib_st_t;

    function automatic logic [OUT_DATA_W-1:0] pack_result(
        input weight_t           err,
        input logic              found,
        input logic              side,
        input logic [CNT_W-1:0]  cnt,
        input logic [MAX_CH-1:0] line,
        input logic              cal,
        input logic              done
    );
        return OUT_DATA_W'({done, cal, line, cnt, side, found, err});
    endfunction

endpackage

// ----- hdl/lsct_calib.sv -----
// white and black capture counters and the learned invert mask
module lsct_calib #(
    parameter int CHANNELS        = 7,
    parameter int CAPTURE_SAMPLES = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lsct_pkg::calib_req_t   req,
    output lsct_pkg::calib_st_t    st
);
    import lsct_pkg::*;

    localparam int SMP_W = $clog2(CAPTURE_SAMPLES + 1);

    logic [SMP_W-1:0]  sum_reg [CHANNELS];
    logic [SMP_W-1:0]  white_reg [CHANNELS];
    logic [SMP_W-1:0]  smp_reg;
    logic              black_reg;
    logic              wdone_reg;
    logic              bdone_reg;
    logic [MAX_CH-1:0] mask_reg;

    logic [SMP_W-1:0]  new_sum [CHANNELS];
    logic [SMP_W-1:0]  new_smp;
    logic [MAX_CH-1:0] new_mask;
    logic              restart;
    logic              done_now;
    logic              wd_after;
    logic              bd_after;

    always_comb
    begin
        restart  = (smp_reg == '0) || (black_reg != req.black);
        new_smp  = (restart ? '0 : smp_reg) + 1'b1;
        done_now = req.capture && (new_smp >= SMP_W'(CAPTURE_SAMPLES));
        new_mask = '0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            new_sum[i]  = (restart ? '0 : sum_reg[i]) + SMP_W'(req.bits[i]);
            new_mask[i] = white_reg[i] > new_sum[i];
        end
        wd_after = wdone_reg || (done_now && !req.black);
        bd_after = bdone_reg || (done_now && req.black);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                sum_reg[i]   <= '0;
                white_reg[i] <= '0;
            end
            smp_reg   <= '0;
            black_reg <= 1'b0;
            wdone_reg <= 1'b0;
            bdone_reg <= 1'b0;
            mask_reg  <= '0;
        end
        else if (req.clear)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                sum_reg[i]   <= '0;
                white_reg[i] <= '0;
            end
            smp_reg   <= '0;
            black_reg <= 1'b0;
            wdone_reg <= 1'b0;
            bdone_reg <= 1'b0;
            mask_reg  <= '0;
        end
        else if (req.capture)
        begin
            sum_reg   <= new_sum;
            black_reg <= req.black;
            if (done_now)
            begin
                smp_reg <= '0;
                if (req.black)
                begin
                    mask_reg  <= new_mask;
                    bdone_reg <= 1'b1;
                end
                else
                begin
                    white_reg <= new_sum;
                    wdone_reg <= 1'b1;
                end
            end
            else
            begin
                smp_reg <= new_smp;
            end
        end
    end

    always_comb
    begin
        st.mask       = mask_reg;
        st.calibrated = wdone_reg && bdone_reg;
        st.done_now   = done_now;
        if (req.clear)
            st.cal_after = 1'b0;
        else if (req.capture)
            st.cal_after = wd_after && bd_after;
        else
            st.cal_after = wdone_reg && bdone_reg;
    end

endmodule

// ----- hdl/lsct_centroid.sv -----
// weighted sum and restoring divide on one shared adder under a small sequencer
module lsct_centroid #(
    parameter int CHANNELS = 7
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lsct_pkg::cen_req_t    req,
    input  lsct_pkg::weight_arr_t weights,
    output lsct_pkg::cen_rsp_t    rsp
);
    import lsct_pkg::*;

    localparam int IDX_W  = $clog2(CHANNELS);
    localparam int STEP_W = $clog2(DIV_STEPS);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(CHANNELS - 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ACC  = 3'd1;
    localparam logic [2:0] ST_ABS  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_SGN  = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [MAX_CH-1:0]    line_reg, line_next;
    logic [SUM_W-1:0]     acc_reg, acc_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic [DIV_STEPS-1:0] quo_reg, quo_next;
    logic                 neg_reg, neg_next;
    weight_t              err_reg, err_next;
    logic                 found_reg, found_next;
    logic                 done_reg, done_next;

    // the one shared add/subtract unit
    logic [SUM_W-1:0] add_a, add_b, add_res;
    logic             add_sub;
    logic [CNT_W-1:0] cnt_inc;
    logic             qbit;
    weight_t          w_sel;

    assign add_res = add_a + (add_b ^ {SUM_W{add_sub}}) + SUM_W'(add_sub);
    assign w_sel   = weights[idx_reg];

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        step_next  = step_reg;
        line_next  = line_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        neg_next   = neg_reg;
        err_next   = err_reg;
        found_next = found_reg;
        done_next  = 1'b0;
        add_a      = '0;
        add_b      = '0;
        add_sub    = 1'b0;
        cnt_inc    = cnt_reg;
        qbit       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.start)
                begin
                    line_next  = req.line;
                    acc_next   = '0;
                    cnt_next   = '0;
                    idx_next   = '0;
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                add_a    = acc_reg;
                add_b    = line_reg[idx_reg] ? {{(SUM_W-W_W){w_sel[W_W-1]}}, w_sel} : '0;
                acc_next = add_res;
                cnt_inc  = cnt_reg + CNT_W'(line_reg[idx_reg]);
                cnt_next = cnt_inc;
                if (idx_reg == LAST_IDX)
                begin
                    if (cnt_inc == '0)
                    begin
                        found_next = 1'b0;
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_ABS;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_ABS:
            begin
                add_b      = acc_reg;
                add_sub    = 1'b1;
                neg_next   = acc_reg[SUM_W-1];
                quo_next   = acc_reg[SUM_W-1] ? add_res[DIV_STEPS-1:0]
                                              : acc_reg[DIV_STEPS-1:0];
                rem_next   = '0;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                // trial subtract of the count from the shifted remainder
                add_a   = SUM_W'({rem_reg, quo_reg[DIV_STEPS-1]});
                add_b   = SUM_W'(cnt_reg);
                add_sub = 1'b1;
                qbit    = !add_res[SUM_W-1];
                if (qbit)
                    rem_next = add_res[CNT_W-1:0];
                else
                    rem_next = {rem_reg[CNT_W-2:0], quo_reg[DIV_STEPS-1]};
                quo_next = {quo_reg[DIV_STEPS-2:0], qbit};
                if (step_reg == LAST_STEP)
                    state_next = ST_SGN;
                else
                    step_next = step_reg + 1'b1;
            end
            ST_SGN:
            begin
                add_b      = SUM_W'(quo_reg);
                add_sub    = 1'b1;
                err_next   = neg_reg ? add_res[W_W-1:0] : quo_reg[W_W-1:0];
                found_next = 1'b1;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            step_reg  <= '0;
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
            found_reg <= found_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        line_reg <= line_next;
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        neg_reg  <= neg_next;
        err_reg  <= err_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.found = found_reg;
    assign rsp.count = cnt_reg;
    assign rsp.err   = err_reg;

endmodule

// ----- hdl/line_sensor_centroid_tracker.sv -----
// top level of the line sensor centroid tracker: handshake, config registers, result register
//
//  channel  | direction | contents (lowest bit first)
//  s_*      | in        | tuser: kind[1:0]; tdata: sensor_bits[6:0], pad
//  m_*      | out       | tdata: position_error, line_found, last_side, active_count,
//           |           |        line_bits, calibrated, capture_done, pad
//  cfg_*    | in        | index 0 global_invert, 1..7 weight_ch0..weight_ch6
//
// a tracking item goes one channel per cycle through the shared adder, then takes the
// magnitude of the sum and runs a 15-step restoring divide on the same adder, then sign
// fix and result load; with no active channel it ends after the last channel is summed
// capture and clear items produce their result in the cycle after transfer
// s_tready is low while a tracking item is in work or a result waits on m_tready
// reset is asynchronous and clears all calibration, held error and side
`include "line_sensor_centroid_tracker_macros.svh"

module line_sensor_centroid_tracker #(
    parameter int CHANNELS        = 7,
    parameter int CAPTURE_SAMPLES = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [lsct_pkg::IN_DATA_W-1:0]      s_tdata,  // sensor_bits[6:0], zero[7]
    input  logic [lsct_pkg::KIND_W-1:0]         s_tuser,  // kind[1:0]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // position_error[12:0], line_found[13], last_side[14], active_count[17:15],
    // line_bits[24:18], calibrated[25], capture_done[26], zero[31:27]
    output logic [lsct_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                                cfg_we,
    input  logic [lsct_pkg::REG_IDX_W-1:0]      cfg_index,
    input  logic [lsct_pkg::W_W-1:0]            cfg_data
);
    import lsct_pkg::*;

    localparam logic [MAX_CH-1:0] CH_MASK = MAX_CH'((1 << CHANNELS) - 1);

    logic                  ginv_reg;
    weight_arr_t           weight_reg;
    weight_t               held_reg, held_next;
    logic                  side_reg, side_next;
    logic                  busy_reg, busy_next;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    // corrected bits of the item in work, kept for its result
    logic [MAX_CH-1:0]     line_keep_reg;

    logic                  accept;
    logic [KIND_W-1:0]     kind;
    logic [MAX_CH-1:0]     raw_bits;
    logic [MAX_CH-1:0]     inv_bits;
    cen_req_t              cen_req;
    cen_rsp_t              cen_rsp;
    calib_req_t            cal_req;
    calib_st_t             cal_st;
    weight_t               err_now;
    logic                  side_now;

    assign kind     = s_tuser;
    assign raw_bits = s_tdata[MAX_CH-1:0] & CH_MASK;
    assign s_tready = !busy_reg && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign inv_bits = cal_st.calibrated ? cal_st.mask : {MAX_CH{ginv_reg}};

    assign cen_req.start = accept && (kind == KIND_TRACK);
    assign cen_req.line  = (raw_bits ^ inv_bits) & CH_MASK;

    assign cal_req.capture = accept && ((kind == KIND_WHITE) || (kind == KIND_BLACK));
    assign cal_req.clear   = accept && (kind == KIND_CLEAR);
    assign cal_req.black   = (kind == KIND_BLACK);
    assign cal_req.bits    = raw_bits;

    lsct_centroid #(
        .CHANNELS (CHANNELS)
    ) u_centroid (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (cen_req),
        .weights (weight_reg),
        .rsp     (cen_rsp)
    );

    lsct_calib #(
        .CHANNELS        (CHANNELS),
        .CAPTURE_SAMPLES (CAPTURE_SAMPLES)
    ) u_calib (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cal_req),
        .st    (cal_st)
    );

    always_comb
    begin
        err_now  = cen_rsp.found ? cen_rsp.err : held_reg;
        side_now = side_reg;
        if (cen_rsp.found && (cen_rsp.err < 0))
            side_now = 1'b0;
        else if (cen_rsp.found && (cen_rsp.err > 0))
            side_now = 1'b1;

        held_next      = held_reg;
        side_next      = side_reg;
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;

        if (cen_rsp.done)
        begin
            held_next      = err_now;
            side_next      = side_now;
            busy_next      = 1'b0;
            out_valid_next = 1'b1;
            out_data_next  = pack_result(err_now, cen_rsp.found, side_now, cen_rsp.count,
                                         line_keep_reg, cal_st.calibrated, 1'b0);
        end
        else if (accept)
        begin
            if (kind == KIND_TRACK)
            begin
                busy_next = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b1;
                out_data_next  = pack_result(held_reg, 1'b0, side_reg, '0, '0,
                                             cal_st.cal_after, cal_st.done_now);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cen_req.start)
            line_keep_reg <= cen_req.line;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ginv_reg      <= 1'b0;
            weight_reg    <= WEIGHT_RST;
            held_reg      <= '0;
            side_reg      <= 1'b0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            held_reg      <= held_next;
            side_reg      <= side_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                if (cfg_index == REG_GLOBAL_INVERT)
                    ginv_reg <= cfg_data[0];
                for (int i = 0; i < MAX_CH; i++)
                begin
                    if (cfg_index == REG_IDX_W'(REG_WEIGHT0 + i))
                        weight_reg[i] <= cfg_data;
                end
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `LSCT_NEVER(a_no_take_busy, busy_reg && s_tready, "input ready while an item is in work")
    `LSCT_ASSERT(a_done_in_work, cen_rsp.done |-> busy_reg, "centroid result with no item in work")
    `LSCT_ASSERT(a_found_count, cen_rsp.done |-> (cen_rsp.found == (cen_rsp.count != '0)),
        "line found flag disagrees with active count")
    `LSCT_ASSERT(a_side_right, (cen_rsp.done && cen_rsp.found && (cen_rsp.err > 0)) |=> side_reg,
        "positive error did not set right side")

endmodule

// ----- verif/line_sensor_centroid_tracker_tb.sv -----
// self-checking testbench for the line sensor centroid tracker
module line_sensor_centroid_tracker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lsct_pkg::*;

    localparam int NCH           = 7;
    localparam int CAP_SAMPLES   = 16;
    localparam int TRACK_LATENCY = NCH + 18;
    localparam int NUM_PHASES    = 6;
    localparam int PHASE_ITEMS   = 255;

    typedef struct packed {
        weight_t          err;
        logic             found;
        logic             side;
        logic [2:0]       cnt;
        logic [NCH-1:0]   line;
        logic             cal;
        logic             done;
    } scan_result_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [NCH-1:0]    bits;
        logic              typed;
        scan_result_t      want;
    } scan_row_t;

    localparam scan_result_t NO_RESULT = '0;

    logic                    clk;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [IN_DATA_W-1:0]    s_tdata;
    logic [KIND_W-1:0]       s_tuser;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OUT_DATA_W-1:0]   m_tdata;
    logic                    cfg_we;
    logic [REG_IDX_W-1:0]    cfg_index;
    logic [W_W-1:0]          cfg_data;

    line_sensor_centroid_tracker #(
        .CHANNELS        (NCH),
        .CAPTURE_SAMPLES (CAP_SAMPLES)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // tracker state as the block should hold it
    logic             invert_all;
    weight_t          chan_weight [NCH];
    logic [NCH-1:0]   learned_mask;
    logic [7:0]       white_tally [NCH];
    logic [7:0]       cap_tally [NCH];
    logic [7:0]       cap_fill;
    logic             cap_black;
    logic             white_ready;
    logic             black_ready;
    weight_t          held_pos;
    logic             held_right;

    scan_result_t     pending_results[$];
    scan_row_t        plan[$];
    int               mismatches;
    int               items_sent;
    int               results_checked;
    int               captures_done;
    int               calibrated_tracks;
    int               settings_used;
    int               hold_len;
    bit               quiet;
    scan_result_t     head;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic scan_result_t predict_scan(logic [KIND_W-1:0] kind,
                                                 logic [NCH-1:0] bits);
        scan_result_t   r;
        logic [NCH-1:0] inv;
        logic [NCH-1:0] line;
        logic [NCH-1:0] m;
        logic           is_black;
        int             sum;
        int             n;
        r = '0;
        case (kind)
            KIND_TRACK:
            begin
                inv  = (white_ready && black_ready) ? learned_mask : {NCH{invert_all}};
                line = bits ^ inv;
                sum  = 0;
                n    = 0;
                for (int i = 0; i < NCH; i++)
                begin
                    if (line[i])
                    begin
                        sum += chan_weight[i];
                        n++;
                    end
                end
                if (n > 0)
                begin
                    held_pos = weight_t'(sum / n);
                    if (held_pos < 0)
                        held_right = 1'b0;
                    else if (held_pos > 0)
                        held_right = 1'b1;
                end
                r.found = (n > 0);
                r.cnt   = 3'(n);
                r.line  = line;
                if (white_ready && black_ready)
                    calibrated_tracks++;
            end
            KIND_WHITE, KIND_BLACK:
            begin
                is_black = (kind == KIND_BLACK);
                // a sample of the other kind abandons the capture in progress
                if (cap_fill == 0 || cap_black != is_black)
                begin
                    foreach (cap_tally[i]) cap_tally[i] = '0;
                    cap_fill  = '0;
                    cap_black = is_black;
                end
                for (int i = 0; i < NCH; i++)
                    cap_tally[i] = cap_tally[i] + 8'(bits[i]);
                cap_fill++;
                if (cap_fill >= CAP_SAMPLES)
                begin
                    r.done   = 1'b1;
                    cap_fill = '0;
                    captures_done++;
                    if (is_black)
                    begin
                        m = '0;
                        for (int i = 0; i < NCH; i++)
                            m[i] = (white_tally[i] > cap_tally[i]);
                        learned_mask = m;
                        black_ready  = 1'b1;
                    end
                    else
                    begin
                        white_tally = cap_tally;
                        white_ready = 1'b1;
                    end
                end
            end
            default:
            begin
                learned_mask = '0;
                foreach (white_tally[i]) white_tally[i] = '0;
                foreach (cap_tally[i]) cap_tally[i] = '0;
                cap_fill    = '0;
                cap_black   = 1'b0;
                white_ready = 1'b0;
                black_ready = 1'b0;
            end
        endcase
        r.err  = held_pos;
        r.side = held_right;
        r.cal  = white_ready && black_ready;
        return r;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // result side: compare every transfer against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got 0x%08h", $time, m_tdata);
                mismatches++;
            end
            else
            begin
                head = pending_results.pop_front();
                check_field("position_error", int'(head.err), int'($signed(m_tdata[12:0])));
                check_field("line_found", int'(head.found), int'(m_tdata[13]));
                check_field("last_side", int'(head.side), int'(m_tdata[14]));
                check_field("active_count", int'(head.cnt), int'(m_tdata[17:15]));
                check_field("line_bits", int'(head.line), int'(m_tdata[24:18]));
                check_field("calibrated", int'(head.cal), int'(m_tdata[25]));
                check_field("capture_done", int'(head.done), int'(m_tdata[26]));
                check_field("padding", 0, int'(m_tdata[31:27]));
                results_checked++;
            end
        end
    end

    // receiver: random stall bursts, plus a long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_len > 0)
            begin
                m_tready = 1'b0;
                repeat (hold_len) @(posedge clk);
                hold_len = 0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            else
                m_tready = 1'b1;
        end
    end

    task automatic send_scan(logic [KIND_W-1:0] kind, logic [NCH-1:0] bits,
                             logic typed = 1'b0, scan_result_t want = NO_RESULT);
        scan_result_t r;
        @(negedge clk);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = {1'b0, bits};
        do
            @(posedge clk);
        while (!s_tready);
        r = predict_scan(kind, bits);
        pending_results.push_back(typed ? want : r);
        items_sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TRACK_LATENCY + 5) @(posedge clk);
    endtask

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [W_W-1:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        if (idx == REG_GLOBAL_INVERT)
            invert_all = val[0];
        else
            chan_weight[idx - REG_WEIGHT0] = weight_t'(val);
        @(posedge clk);
    endtask

    task automatic apply_setting(logic inv, weight_t w [NCH]);
        write_reg(REG_GLOBAL_INVERT, W_W'(inv));
        for (int i = 0; i < NCH; i++)
            write_reg(REG_WEIGHT0 + REG_IDX_W'(i), w[i]);
        @(negedge clk);
        cfg_we = 1'b0;
        settings_used++;
    endtask

    function automatic logic [NCH-1:0] random_scan();
        case ($urandom_range(0, 4))
            0:       return NCH'(1 << $urandom_range(0, NCH - 1));
            1:       return NCH'(3 << $urandom_range(0, NCH - 2));
            2:       return $urandom_range(0, 1) ? '0 : '1;
            default: return NCH'($urandom);
        endcase
    endfunction

    // capture sample: the surface pattern with about one bit in eight flipped
    function automatic logic [NCH-1:0] noisy(logic [NCH-1:0] pattern);
        return pattern ^ (NCH'($urandom) & NCH'($urandom) & NCH'($urandom));
    endfunction

    task automatic capture_run(logic [KIND_W-1:0] kind, logic [NCH-1:0] pattern, int len);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_scan(KIND_TRACK, random_scan());
            send_scan(kind, noisy(pattern));
        end
    endtask

    task automatic run_phase(int stop_at);
        logic [NCH-1:0] line_pat;
        int             n;
        while (items_sent < stop_at)
        begin
            line_pat = NCH'($urandom);
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    // full calibration: white surface, then black, then tracking
                    if ($urandom_range(0, 1) == 0)
                        send_scan(KIND_CLEAR, NCH'($urandom));
                    capture_run(KIND_WHITE, line_pat, CAP_SAMPLES);
                    capture_run(KIND_BLACK, ~line_pat ^ noisy('0), CAP_SAMPLES);
                    n = $urandom_range(5, 20);
                    repeat (n) send_scan(KIND_TRACK, random_scan());
                end
                4:
                begin
                    capture_run(KIND_BLACK, line_pat, CAP_SAMPLES);
                    repeat ($urandom_range(2, 8)) send_scan(KIND_TRACK, random_scan());
                end
                5:
                begin
                    // broken capture: partial run then a second run of either kind
                    capture_run($urandom_range(0, 1) ? KIND_WHITE : KIND_BLACK, line_pat,
                                $urandom_range(1, CAP_SAMPLES - 1));
                    capture_run($urandom_range(0, 1) ? KIND_WHITE : KIND_BLACK, ~line_pat,
                                $urandom_range(1, CAP_SAMPLES));
                end
                6:
                    send_scan(KIND_CLEAR, NCH'($urandom));
                default:
                begin
                    n = $urandom_range(1, 20);
                    repeat (n) send_scan(KIND_TRACK, random_scan());
                end
            endcase
        end
    endtask

    initial
    begin
        weight_t w [NCH];
        logic    inv;

        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = KIND_TRACK;
        cfg_we    = 1'b0;
        cfg_index = REG_GLOBAL_INVERT;
        cfg_data  = '0;
        quiet     = 1'b0;
        hold_len  = 0;
        mismatches        = 0;
        items_sent        = 0;
        results_checked   = 0;
        captures_done     = 0;
        calibrated_tracks = 0;
        settings_used     = 0;

        invert_all = 1'b0;
        for (int i = 0; i < NCH; i++)
            chan_weight[i] = weight_t'((i - 3) * 1000);
        learned_mask = '0;
        foreach (white_tally[i]) white_tally[i] = '0;
        foreach (cap_tally[i]) cap_tally[i] = '0;
        cap_fill    = '0;
        cap_black   = 1'b0;
        white_ready = 1'b0;
        black_ready = 1'b0;
        held_pos    = '0;
        held_right  = 1'b0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed rows on reset weights; typed results are the obvious ones
        plan.push_back('{KIND_TRACK, 7'h00, 1'b1,
                         '{13'sd0, 1'b0, 1'b0, 3'd0, 7'h00, 1'b0, 1'b0}});
        plan.push_back('{KIND_TRACK, 7'h7F, 1'b1,
                         '{13'sd0, 1'b1, 1'b0, 3'd7, 7'h7F, 1'b0, 1'b0}});
        plan.push_back('{KIND_TRACK, 7'h01, 1'b1,
                         '{-13'sd3000, 1'b1, 1'b0, 3'd1, 7'h01, 1'b0, 1'b0}});
        plan.push_back('{KIND_TRACK, 7'h40, 1'b1,
                         '{13'sd3000, 1'b1, 1'b1, 3'd1, 7'h40, 1'b0, 1'b0}});
        plan.push_back('{KIND_TRACK, 7'h00, 1'b1,
                         '{13'sd3000, 1'b0, 1'b1, 3'd0, 7'h00, 1'b0, 1'b0}});
        plan.push_back('{KIND_TRACK, 7'h03, 1'b0, NO_RESULT});
        plan.push_back('{KIND_TRACK, 7'h07, 1'b0, NO_RESULT});
        // zero error keeps the side
        plan.push_back('{KIND_TRACK, 7'h2A, 1'b0, NO_RESULT});
        plan.push_back('{KIND_TRACK, 7'h60, 1'b0, NO_RESULT});
        plan.push_back('{KIND_WHITE, 7'h55, 1'b0, NO_RESULT});
        plan.push_back('{KIND_WHITE, 7'h7F, 1'b0, NO_RESULT});
        // tracking in the middle of a capture
        plan.push_back('{KIND_TRACK, 7'h10, 1'b0, NO_RESULT});
        plan.push_back('{KIND_WHITE, 7'h00, 1'b0, NO_RESULT});
        // kind switch abandons the white capture
        plan.push_back('{KIND_BLACK, 7'h7F, 1'b0, NO_RESULT});
        plan.push_back('{KIND_BLACK, 7'h0F, 1'b0, NO_RESULT});
        plan.push_back('{KIND_WHITE, 7'h3C, 1'b0, NO_RESULT});
        plan.push_back('{KIND_CLEAR, 7'h7F, 1'b0, NO_RESULT});
        plan.push_back('{KIND_TRACK, 7'h7E, 1'b0, NO_RESULT});
        plan.push_back('{KIND_CLEAR, 7'h00, 1'b0, NO_RESULT});
        plan.push_back('{KIND_TRACK, 7'h08, 1'b0, NO_RESULT});

        foreach (plan[i])
            send_scan(plan[i].kind, plan[i].bits, plan[i].typed, plan[i].want);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain();
            case (p)
                0:
                begin
                    inv = 1'b0;
                    for (int i = 0; i < NCH; i++) w[i] = weight_t'((i - 3) * 1000);
                end
                1:
                begin
                    inv = 1'b1;
                    for (int i = 0; i < NCH; i++) w[i] = -13'sd4096;
                end
                2:
                begin
                    inv = 1'b0;
                    for (int i = 0; i < NCH; i++) w[i] = 13'sd4095;
                end
                3:
                begin
                    inv = 1'b1;
                    for (int i = 0; i < NCH; i++) w[i] = i[0] ? 13'sd4095 : -13'sd4096;
                end
                default:
                begin
                    inv = 1'($urandom);
                    for (int i = 0; i < NCH; i++) w[i] = weight_t'($urandom);
                end
            endcase
            apply_setting(inv, w);
            if (p == 2)
                hold_len = 300;
            if (p == NUM_PHASES - 1)
                quiet = 1'b1;
            run_phase(items_sent + PHASE_ITEMS);
        end

        drain();
        $display("covered %0d scans across %0d register settings, %0d results checked",
                 items_sent, settings_used, results_checked);
        $display("%0d captures completed, %0d scans tracked with a learned mask",
                 captures_done, calibrated_tracks);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

endmodule
